// ===== design/q2e_pkg.sv =====
// q2e_pkg: shared constants and tables for the quaternion to Euler bins unit.
// No dependencies.
package q2e_pkg;
	localparam int BIN_SCALE_DEF = 18;
	localparam int COMPONENT_BITS_DEF = 16;
	localparam int CORDIC_STAGES = 28;
	localparam int BIN_W = 5;
	localparam int ROOT_W = 29;

	function automatic logic [31:0] atan_phase(input int i);
		logic [31:0] t;
		case (i)
			0: t = 32'h20000000; 1: t = 32'h12E4051E; 2: t = 32'h09FB385B;
			3: t = 32'h051111D4; 4: t = 32'h028B0D43; 5: t = 32'h0145D7E1;
			6: t = 32'h00A2F61E; 7: t = 32'h00517C55; 8: t = 32'h0028BE53;
			9: t = 32'h00145F2F; 10: t = 32'h000A2F98; 11: t = 32'h000517CC;
			12: t = 32'h00028BE6; 13: t = 32'h000145F3; 14: t = 32'h0000A2FA;
			15: t = 32'h0000517D; 16: t = 32'h000028BE; 17: t = 32'h0000145F;
			18: t = 32'h00000A30; 19: t = 32'h00000518; 20: t = 32'h0000028C;
			21: t = 32'h00000146; 22: t = 32'h000000A3; 23: t = 32'h00000051;
			24: t = 32'h00000029; 25: t = 32'h00000014; 26: t = 32'h0000000A;
			27: t = 32'h00000005;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

	// products formed by the front part
	typedef struct packed {
		logic signed [63:0] rn;
		logic signed [63:0] rd;
		logic signed [63:0] yn;
		logic signed [63:0] yd;
		logic signed [63:0] p;
	} prod_t;
endpackage

// ===== design/q2e_front.sv =====
// q2e_front: input stage; narrows components and forms the five products, registered.
// Depends on q2e_pkg.
module q2e_front #(
	parameter int COMPONENT_BITS = q2e_pkg::COMPONENT_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [4*COMPONENT_BITS-1:0] in_data,
	output logic                      out_valid,
	input  logic                      out_ready,
	output q2e_pkg::prod_t            out_data
);
	localparam int WB = (COMPONENT_BITS > 24) ? 24 : COMPONENT_BITS;
	localparam int FRAC2 = 2 * (WB - 2);
	localparam int SH = COMPONENT_BITS - WB;

	logic signed [WB-1:0] c_w[4];
	logic signed [WB-1:0] w, x, y, z;
	logic signed [2*WB-1:0] wx_s1, yz_s1, xx_s1, yy_s1, zz_s1, wz_s1, xy_s1, wy_s1, zx_s1;
	logic v_s1, v_s2;
	q2e_pkg::prod_t d_s2;
	logic adv1, adv2;

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			c_w[i] = WB'($signed(in_data[i*COMPONENT_BITS +: COMPONENT_BITS]) >>> SH);
		end
		w = c_w[0]; x = c_w[1]; y = c_w[2]; z = c_w[3];
	end

	assign adv2 = !v_s2 || out_ready;
	assign adv1 = !v_s1 || adv2;
	assign in_ready = adv1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (adv1) v_s1 <= in_valid;
			if (adv2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1 && in_valid) begin
			wx_s1 <= w * x; yz_s1 <= y * z; xx_s1 <= x * x; yy_s1 <= y * y;
			zz_s1 <= z * z; wz_s1 <= w * z; xy_s1 <= x * y; wy_s1 <= w * y;
			zx_s1 <= z * x;
		end
		if (adv2 && v_s1) begin
			d_s2.rn <= 64'(wx_s1) + 64'(yz_s1);
			d_s2.rd <= (64'sd1 <<< (FRAC2 - 1)) - (64'(xx_s1) + 64'(yy_s1));
			d_s2.yn <= 64'(wz_s1) + 64'(xy_s1);
			d_s2.yd <= (64'sd1 <<< (FRAC2 - 1)) - (64'(yy_s1) + 64'(zz_s1));
			d_s2.p  <= 64'(wy_s1) - 64'(zx_s1);
		end
	end

	assign out_valid = v_s2;
	assign out_data = d_s2;
endmodule

// ===== design/q2e_fifo.sv =====
// q2e_fifo: short queue between the front and back parts.
// Depends on q2e_pkg.
module q2e_fifo #(
	parameter int DEPTH = 4
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  q2e_pkg::prod_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output q2e_pkg::prod_t out_data
);
	localparam int AW = $clog2(DEPTH);
	q2e_pkg::prod_t mem_q[DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic wr, rd;

	assign in_ready = cnt_q != (AW+1)'(DEPTH);
	assign out_valid = cnt_q != '0;
	assign wr = in_valid && in_ready;
	assign rd = out_valid && out_ready;
	assign out_data = mem_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= in_data;
	end
endmodule

// ===== design/q2e_back.sv =====
// q2e_back: pipelined square root, three unrolled CORDIC vectoring pipes and binning.
// Depends on q2e_pkg.
module q2e_back #(
	parameter int BIN_SCALE = q2e_pkg::BIN_SCALE_DEF,
	parameter int COMPONENT_BITS = q2e_pkg::COMPONENT_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  q2e_pkg::prod_t in_data,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [3*q2e_pkg::BIN_W-1:0] out_data
);
	localparam int WB = (COMPONENT_BITS > 24) ? 24 : COMPONENT_BITS;
	localparam int FRAC2 = 2 * (WB - 2);
	localparam int NS = q2e_pkg::CORDIC_STAGES;
	localparam int RW = q2e_pkg::ROOT_W;
	localparam int NR = RW;             // root bits, one per stage
	localparam int L = NR + NS + 2;     // output register stage
	localparam int BW = q2e_pkg::BIN_W;

	// stage 0: clamp sine, set up root
	// stages 1..NR: restoring square root one bit each
	// stage NR+1: prep three CORDIC inputs
	// NS stages CORDIC, then binning into the output register
	logic [L:0] v;
	logic adv;
	assign adv = !v[L] || out_ready;
	assign in_ready = adv;
	assign out_valid = v[L];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v <= '0;
		else if (adv) v <= {v[L-1:0], in_valid};
	end

	// carried numbers
	logic signed [63:0] rn_q[NR+1], rd_q[NR+1], yn_q[NR+1], yd_q[NR+1];
	logic signed [31:0] s_q[NR+1];
	logic [57:0] rem_q[NR+1];
	logic [RW-1:0] root_q[NR+1];
	logic [28:0] sabs_q;

	logic signed [63:0] ps, pc;
	always_comb begin
		ps = in_data.p <<< 1;
		if (ps > (64'sd1 <<< FRAC2)) ps = 64'sd1 <<< FRAC2;
		if (ps < -(64'sd1 <<< FRAC2)) ps = -(64'sd1 <<< FRAC2);
		if (FRAC2 > 28) pc = ps >>> (FRAC2 > 28 ? FRAC2 - 28 : 0);
		else pc = ps <<< (FRAC2 < 28 ? 28 - FRAC2 : 0);
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rn_q[0] <= in_data.rn; rd_q[0] <= in_data.rd;
			yn_q[0] <= in_data.yn; yd_q[0] <= in_data.yd;
			s_q[0] <= 32'(pc);
			sabs_q <= 29'(pc < 0 ? -pc : pc);
			root_q[0] <= '0;
			rem_q[0] <= '0;
		end
	end

	// square root of 2^56 - s^2 by digit recurrence
	logic [57:0] sq, rad;
	assign sq = sabs_q * sabs_q;
	assign rad = (58'd1 << 56) - sq;

	genvar g, h;
	generate
		for (g = 1; g <= NR; g++) begin : g_root
			logic [57:0] rm, tr;
			logic [RW-1:0] rt;
			always_comb begin
				rm = (g == 1) ? rad : rem_q[g-1];
				rt = root_q[g-1];
				tr = 58'({rt, 2'b01}) << (2 * (NR - g));
				if (rm >= tr) begin
					rm = rm - tr;
					rt = {rt[RW-2:0], 1'b1};
				end else begin
					rt = {rt[RW-2:0], 1'b0};
				end
			end
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_q[g] <= rm; root_q[g] <= rt;
					rn_q[g] <= rn_q[g-1]; rd_q[g] <= rd_q[g-1];
					yn_q[g] <= yn_q[g-1]; yd_q[g] <= yd_q[g-1];
					s_q[g] <= s_q[g-1];
				end
			end
		end
	endgenerate

	// special-case marks carried with each lane
	localparam logic [1:0] SP_NONE = 2'd0; // normal CORDIC result
	localparam logic [1:0] SP_MAX  = 2'd1; // force top bin
	localparam logic [1:0] SP_ZERO = 2'd2; // force bin zero
	localparam logic [1:0] SP_MID  = 2'd3; // force middle of the circle

	// CORDIC lanes: 0 roll, 1 pitch, 2 yaw
	typedef struct packed {
		logic signed [65:0] x;
		logic signed [65:0] y;
		logic [31:0] z;
		logic [1:0] sp;
	} lane_t;

	lane_t ln_q[3][NS+1];
	lane_t pre[3];

	always_comb begin
		logic signed [63:0] n, d;
		for (int k = 0; k < 3; k++) begin
			n = (k == 0) ? rn_q[NR] : (k == 2) ? yn_q[NR] : 64'(s_q[NR]);
			d = (k == 0) ? rd_q[NR] : (k == 2) ? yd_q[NR] : 64'(root_q[NR]);
			pre[k].sp = SP_NONE;
			if (k == 1) begin
				if (d == 0) pre[k].sp = (n > 0) ? SP_MAX : SP_ZERO;
			end else begin
				if (n == 0 && d == 0) pre[k].sp = SP_MID;
				else if (n == 0 && d < 0) pre[k].sp = SP_MAX;
			end
			if (d < 0) begin
				pre[k].x = -66'(d); pre[k].y = -66'(n); pre[k].z = 32'h80000000;
			end else begin
				pre[k].x = 66'(d); pre[k].y = 66'(n); pre[k].z = '0;
			end
		end
	end

	generate
		for (g = 0; g <= NS; g++) begin : g_cordic
			for (h = 0; h < 3; h++) begin : g_lane
				if (g == 0) begin : g_first
					always_ff @(posedge clk) begin
						if (adv) ln_q[h][0] <= pre[h];
					end
				end else begin : g_step
					always_ff @(posedge clk) begin
						if (adv) begin
							ln_q[h][g].sp <= ln_q[h][g-1].sp;
							if (ln_q[h][g-1].y > 0) begin
								ln_q[h][g].x <= ln_q[h][g-1].x + (ln_q[h][g-1].y >>> (g-1));
								ln_q[h][g].y <= ln_q[h][g-1].y - (ln_q[h][g-1].x >>> (g-1));
								ln_q[h][g].z <= ln_q[h][g-1].z + q2e_pkg::atan_phase(g-1);
							end else begin
								ln_q[h][g].x <= ln_q[h][g-1].x - (ln_q[h][g-1].y >>> (g-1));
								ln_q[h][g].y <= ln_q[h][g-1].y + (ln_q[h][g-1].x >>> (g-1));
								ln_q[h][g].z <= ln_q[h][g-1].z - q2e_pkg::atan_phase(g-1);
							end
						end
					end
				end
			end
		end
	endgenerate

	// binning: phase times scale, top bits
	logic [BW-1:0] bin[3];
	always_comb begin
		logic [31:0] u;
		logic signed [32:0] a;
		logic [40:0] m;
		for (int k = 0; k < 3; k++) begin
			u = '0;
			a = '0;
			m = '0;
			if (k == 1) begin
				a = 33'($signed(ln_q[k][NS].z)) + 33'sd1073741824;
				m = 41'(a[31:0]) * 41'(BIN_SCALE);
				bin[k] = (m[40:31] > 10'(BIN_SCALE)) ? BW'(BIN_SCALE) : BW'(m[40:31]);
				if (a < 0) bin[k] = '0;
			end else begin
				u = ln_q[k][NS].z + 32'h80000000;
				if (ln_q[k][NS].sp == SP_MID) u = 32'h80000000;
				m = 41'(u) * 41'(BIN_SCALE);
				bin[k] = BW'(m[40:32]);
			end
			if (ln_q[k][NS].sp == SP_MAX) bin[k] = BW'(BIN_SCALE);
			else if (ln_q[k][NS].sp == SP_ZERO) bin[k] = '0;
		end
	end

	logic [3*BW-1:0] res_q;
	always_ff @(posedge clk) begin
		if (adv) res_q <= {bin[2], bin[1], bin[0]};
	end
	assign out_data = res_q;
endmodule

// ===== design/quaternion_to_euler_bins_unit.sv =====
// quaternion_to_euler_bins_unit: top level of the quaternion to Euler-angle bins block.
// Depends on q2e_pkg, q2e_front, q2e_fifo, q2e_back.
//
// Usage:
//  Slave channel s_axis_*: one beat carries a quaternion w, x, y, z.
//  Master channel m_axis_*: one beat carries roll, pitch and yaw bins.
//  One result beat per input beat, in order.
//  Throughput: one beat per cycle while the receiver accepts, set by fully pipelined
//  multipliers, square root (one root bit per stage) and unrolled CORDIC stages.
//  Path: the product registers of the front end, the queue, then the
//  back end (sine clamp, 29 root stages, CORDIC setup, 28 CORDIC stages
//  and the binned output register).
//  Reset (arst_n low) empties every stage and the queue; no beat is shown.
//  When the receiver stalls, the back pipe holds, the queue fills, then
//  the front holds and s_axis_tready falls; no beat is lost.
module quaternion_to_euler_bins_unit #(
	parameter int BIN_SCALE = q2e_pkg::BIN_SCALE_DEF,
	parameter int COMPONENT_BITS = q2e_pkg::COMPONENT_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// quat_w, quat_x, quat_y, quat_z from bit 0 up
	input  logic [((4*COMPONENT_BITS+7)/8)*8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// roll_bin, pitch_bin, yaw_bin from bit 0 up, zero filled
	output logic [15:0] m_axis_tdata
);
	q2e_pkg::prod_t f_data, q_data;
	logic f_valid, f_ready, q_valid, q_ready;
	logic [3*q2e_pkg::BIN_W-1:0] res;

	q2e_front #(.COMPONENT_BITS(COMPONENT_BITS)) u_front (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_data(s_axis_tdata[4*COMPONENT_BITS-1:0]),
		.out_valid(f_valid), .out_ready(f_ready), .out_data(f_data)
	);

	q2e_fifo #(.DEPTH(4)) u_fifo (
		.clk, .arst_n,
		.in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
		.out_valid(q_valid), .out_ready(q_ready), .out_data(q_data)
	);

	q2e_back #(.BIN_SCALE(BIN_SCALE), .COMPONENT_BITS(COMPONENT_BITS)) u_back (
		.clk, .arst_n,
		.in_valid(q_valid), .in_ready(q_ready), .in_data(q_data),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_data(res)
	);

	assign m_axis_tdata = {1'b0, res};
endmodule

// ===== test/quaternion_to_euler_bins_unit_test.sv =====
// Self-checking bench for quaternion_to_euler_bins_unit: drives quaternion beats and
// checks roll, pitch and yaw bins against an integer CORDIC predictor held in a scoreboard.
// Depends on q2e_pkg and the RTL of the block only.
module quaternion_to_euler_bins_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = q2e_pkg::COMPONENT_BITS_DEF;
	localparam int BINS = q2e_pkg::BIN_SCALE_DEF;
	localparam int LIMIT = 400000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic [4:0] roll;
		logic [4:0] pitch;
		logic [4:0] yaw;
	} angle_bins_t;

	// Scoreboard: bins predicted per accepted quaternion, checked in order.
	class euler_bins_board;
		angle_bins_t pending_bins[$];
		int mismatches;
		int checked;

		function longint unsigned root_floor(longint unsigned v);
			longint unsigned r;
			longint unsigned b;
			r = 0;
			b = 64'd1 << 62;
			while (b > v)
				b = b >> 2;
			while (b != 0) begin
				if (v >= r + b) begin
					v = v - (r + b);
					r = (r >> 1) + b;
				end else begin
					r = r >> 1;
				end
				b = b >> 2;
			end
			return r;
		endfunction

		// vectoring CORDIC, 2^32 phase units per turn
		function logic [31:0] vector_phase(longint vx, longint vy);
			logic [31:0] ph;
			longint dx;
			longint dy;
			ph = '0;
			if (vx < 0) begin
				vx = -vx;
				vy = -vy;
				ph = 32'h8000_0000;
			end
			for (int i = 0; i < q2e_pkg::CORDIC_STAGES; i++) begin
				dx = vy >>> i;
				dy = vx >>> i;
				if (vy > 0) begin
					vx = vx + dx;
					vy = vy - dy;
					ph = ph + q2e_pkg::atan_phase(i);
				end else begin
					vx = vx - dx;
					vy = vy + dy;
					ph = ph - q2e_pkg::atan_phase(i);
				end
			end
			return ph;
		endfunction

		function logic [4:0] circle_bin(longint num, longint den);
			logic [31:0] u;
			longint unsigned b;
			if (num == 0 && den == 0)
				u = 32'h8000_0000;
			else if (num == 0 && den < 0)
				return 5'(BINS);
			else
				u = vector_phase(den, num) + 32'h8000_0000;
			b = (longint'(u) * BINS) >> 32;
			return b > BINS ? 5'(BINS) : 5'(b);
		endfunction

		// pitch from the Q2.28 half-sine product
		function logic [4:0] elevation_bin(longint prod);
			longint one;
			longint s;
			longint c;
			longint a;
			longint v;
			logic [31:0] ph;
			longint unsigned b;
			one = 64'sd1 <<< 28;
			s = 2 * prod;
			if (s > one) s = one;
			if (s < -one) s = -one;
			c = longint'(root_floor((64'd1 << 56) - longint'(s * s)));
			if (c == 0)
				return s > 0 ? 5'(BINS) : 5'd0;
			ph = vector_phase(c, s);
			a = ph[31] ? longint'(ph) - (64'sd1 <<< 32) : longint'(ph);
			v = a + (64'sd1 <<< 30);
			if (v < 0)
				return 5'd0;
			b = longint'(v * BINS) >> 31;
			return b > BINS ? 5'(BINS) : 5'(b);
		endfunction

		function void note_quaternion(logic [4*CW-1:0] beat);
			longint w;
			longint x;
			longint y;
			longint z;
			longint half;
			angle_bins_t e;
			w = longint'($signed(beat[0*CW +: CW]));
			x = longint'($signed(beat[1*CW +: CW]));
			y = longint'($signed(beat[2*CW +: CW]));
			z = longint'($signed(beat[3*CW +: CW]));
			half = 64'sd1 <<< 27;
			e.roll = circle_bin(w * x + y * z, half - (x * x + y * y));
			e.pitch = elevation_bin(w * y - z * x);
			e.yaw = circle_bin(w * z + x * y, half - (y * y + z * z));
			pending_bins.push_back(e);
		endfunction

		function void check_bins(logic [15:0] beat);
			angle_bins_t e;
			if (pending_bins.size() == 0) begin
				$error("result beat %h with nothing expected", beat);
				mismatches++;
				return;
			end
			e = pending_bins.pop_front();
			checked++;
			if (beat[4:0] !== e.roll) begin
				$error("roll_bin: expected %0d, got %0d", e.roll, beat[4:0]);
				mismatches++;
			end
			if (beat[9:5] !== e.pitch) begin
				$error("pitch_bin: expected %0d, got %0d", e.pitch, beat[9:5]);
				mismatches++;
			end
			if (beat[14:10] !== e.yaw) begin
				$error("yaw_bin: expected %0d, got %0d", e.yaw, beat[14:10]);
				mismatches++;
			end
			if (beat[15] !== 1'b0) begin
				$error("fill bit: expected 0, got %b", beat[15]);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_axis_tvalid = 0;
	logic s_axis_tready;
	logic [((4*CW+7)/8)*8-1:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 0;
	logic [15:0] m_axis_tdata;

	euler_bins_board board = new();
	bit steady = 0;     // no idling on either side
	bit hold_out = 0;   // receiver long hold-off request
	int cycles = 0;
	int sent = 0;

	always #6 clk = ~clk;

	quaternion_to_euler_bins_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// monitors: sample at the rising edge
	always @(posedge clk) begin
		if (arst_n && s_axis_tvalid && s_axis_tready)
			board.note_quaternion(s_axis_tdata[4*CW-1:0]);
		if (arst_n && m_axis_tvalid && m_axis_tready)
			board.check_bins(m_axis_tdata);
	end

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("quaternion_to_euler_bins_unit test failed");
			$finish;
		end
	end

	// receiver: random stalls, or a long hold-off counted here
	initial begin
		int held;
		forever begin
			@(negedge clk);
			if (hold_out) begin
				m_axis_tready <= 0;
				for (held = 0; held < HOLD_CYCLES; held++)
					@(negedge clk);
				hold_out = 0;
				m_axis_tready <= 1;
			end else begin
				m_axis_tready <= steady || ($urandom_range(0, 99) >= 33);
			end
		end
	end

	task automatic send_quat(logic signed [CW-1:0] w, logic signed [CW-1:0] x,
			logic signed [CW-1:0] y, logic signed [CW-1:0] z);
		while (!steady && $urandom_range(0, 99) < 33) begin
			@(negedge clk);
			s_axis_tvalid <= 0;
		end
		@(negedge clk);
		s_axis_tvalid <= 1;
		s_axis_tdata <= {z, y, x, w};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent++;
	endtask

	task automatic drain_all();
		@(negedge clk);
		s_axis_tvalid <= 0;
		while (board.pending_bins.size() != 0)
			@(posedge clk);
	endtask

	// random unit quaternion truncated to Q1.14
	task automatic send_unit_quat();
		real c[4];
		real n;
		n = 0.0;
		while (n < 1.0e-3) begin
			n = 0.0;
			foreach (c[i]) begin
				c[i] = real'(int'($urandom_range(0, 65536)) - 32768) / 32768.0;
				n += c[i] * c[i];
			end
		end
		n = $sqrt(n);
		send_quat(CW'($rtoi(c[0] / n * 16384.0)), CW'($rtoi(c[1] / n * 16384.0)),
			CW'($rtoi(c[2] / n * 16384.0)), CW'($rtoi(c[3] / n * 16384.0)));
	endtask

	function automatic logic [CW-1:0] any_comp();
		return CW'(int'($urandom_range(0, 32768)) - 16384);
	endfunction

	initial begin
		int pick;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		// directed: identity, axis turns, poles, degenerate atan2 inputs
		send_quat(16384, 0, 0, 0);
		send_quat(-16384, 0, 0, 0);
		send_quat(0, 16384, 0, 0);      // roll numerator zero, negative x axis
		send_quat(0, 0, 0, 16384);      // yaw on negative x axis
		send_quat(0, 0, 16384, 0);
		send_quat(0, -16384, 0, 0);
		send_quat(0, 8192, 8192, 0);    // zero vector for roll atan2
		send_quat(0, 0, 8192, 8192);    // zero vector for yaw atan2
		send_quat(11585, 0, 11585, 0);  // pitch near +90
		send_quat(11585, 0, -11585, 0); // pitch near -90
		send_quat(16384, 0, 16384, 0);  // sine clamped at +1, pole
		send_quat(16384, 0, -16384, 0); // sine clamped at -1, pole
		send_quat(0, 0, 0, 0);
		send_quat(16384, 16384, 16384, 16384);
		send_quat(-16384, -16384, -16384, -16384);
		send_quat(16384, -16384, 16384, -16384);
		send_quat(-32768, 32767, -32768, 32767); // out-of-range raw codes
		send_quat(32767, -32768, 32767, -32768);
		send_quat(11585, 11585, 0, 0);
		send_quat(8192, 8192, 8192, 8192);
		send_quat(8192, -8192, 8192, -8192);
		drain_all();

		for (int n = 0; n < 750; n++) begin
			steady = (n >= 250 && n < 350);
			if (n == 400)
				hold_out = 1;
			if (n == 550)
				drain_all();
			pick = $urandom_range(0, 99);
			if (pick < 75)
				send_unit_quat();
			else if (pick < 92)
				send_quat(any_comp(), any_comp(), any_comp(), any_comp());
			else
				send_quat(CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom));
		end
		steady = 0;
		drain_all();
		repeat (80) @(posedge clk);

		$display("Sent %0d quaternion beats (axes, poles, degenerate atan2, unit and raw codes),",
			sent);
		$display("checked %0d result beats with stalls, a long hold-off and a full drain.",
			board.checked);
		if (board.mismatches == 0 && board.pending_bins.size() == 0)
			$display("quaternion_to_euler_bins_unit test passed");
		else
			$display("quaternion_to_euler_bins_unit test failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
design/q2e_pkg.sv
design/q2e_front.sv
design/q2e_fifo.sv
design/q2e_back.sv
design/quaternion_to_euler_bins_unit.sv
test/quaternion_to_euler_bins_unit_test.sv
